[rtl/string_keyed_direct_mapped_lookup_unit_macros.svh]
// Assertion macros shared by the lookup unit RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef STRING_KEYED_DIRECT_MAPPED_LOOKUP_UNIT_MACROS_SVH
`define STRING_KEYED_DIRECT_MAPPED_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define SKDML_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKDML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/skdml_pkg.sv]
// Shared constants for the string-keyed direct-mapped lookup unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package skdml_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int PATH_BYTES_DEF    = 128;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;
  localparam int ID_W   = 16;

  // request kinds, taken from the first beat of a request
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DEL    = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

endpackage

`default_nettype wire

[rtl/skdml_mod_unit.sv]
// Remainder of a 32-bit hash by the table size.
// Power-of-two sizes register the low bits; others use a reciprocal multiply. Uses skdml_pkg.
`default_nettype none

module skdml_mod_unit
  import skdml_pkg::*;
#(
  parameter int DIVISOR = TABLE_ENTRIES_DEF,
  parameter int SW      = $clog2(DIVISOR)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] value,
  output      logic              done,
  output      logic [SW-1:0]     rem
);

  logic          done_r;
  logic [SW-1:0] rem_r;

  generate
    if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_pow2
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= value[SW-1:0];
        end
      end
    end else begin : g_recip
      // round-up reciprocal: t = high word of n * MAGIC, q = (t + ((n - t) >> 1)) >> (SW - 1)
      localparam logic [2*HASH_W-1:0] M_FULL =
        (((64'd1 << HASH_W) * 64'((2 ** SW) - DIVISOR)) / 64'(DIVISOR)) + 64'd1;
      localparam logic [HASH_W-1:0] MAGIC = M_FULL[HASH_W-1:0];

      logic                v1_r;
      logic                v2_r;
      logic                v3_r;
      logic [HASH_W-1:0]   num_r;
      logic [HASH_W-1:0]   hi_r;
      logic [HASH_W-1:0]   quo_r;
      logic [2*HASH_W-1:0] prod;
      logic [HASH_W-1:0]   quo_nxt;

      always_comb begin
        prod    = (2*HASH_W)'(num_r) * (2*HASH_W)'(MAGIC);
        quo_nxt = (hi_r + ((num_r - hi_r) >> 1)) >> (SW - 1);
      end

      // hold the dividend; the remainder fits in SW bits, so only the low bits are formed
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r   <= 1'b0;
          v2_r   <= 1'b0;
          v3_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          v1_r   <= start;
          v2_r   <= v1_r;
          v3_r   <= v2_r;
          done_r <= v3_r;
        end
        if (start) begin
          num_r <= value;
        end
        hi_r  <= prod[2*HASH_W-1:HASH_W];
        quo_r <= quo_nxt;
        rem_r <= num_r[SW-1:0] - (quo_r[SW-1:0] * SW'(DIVISOR));
      end
    end
  endgenerate

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/skdml_path_store.sv]
// Path byte memory: one row per slot plus a scratch row for the incoming path.
// One write port, two registered read ports. Uses skdml_pkg.
`default_nettype none

module skdml_path_store
  import skdml_pkg::*;
#(
  parameter int DEPTH = (TABLE_ENTRIES_DEF + 1) * PATH_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_a_addr,
  input  wire logic [AW-1:0]     rd_b_addr,
  output      logic [BYTE_W-1:0] rd_a_data,
  output      logic [BYTE_W-1:0] rd_b_data
);

  logic [BYTE_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

[rtl/string_keyed_direct_mapped_lookup_unit.sv]
// Input: one path byte per cycle while in_stall is low; the hash folds in the same cycle,
// so n bytes take n beats. End of request: slot = hash mod TABLE_ENTRIES via the low bits
// (power of two) or a reciprocal multiply. Add then copies len bytes at 1 per cycle and
// writes slot info; lookup reads slot info and compares len bytes; delete and too-long
// finish at once. Results wait for the output register. Reset: clears all slot info, input
// stalled. One request is in the back end at a time; the next streams in once staged.
`default_nettype none
`include "string_keyed_direct_mapped_lookup_unit_macros.svh"

module string_keyed_direct_mapped_lookup_unit
  import skdml_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int PATH_BYTES    = PATH_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [BYTE_W-1:0] in_path_byte,
  input  wire logic              in_last_byte,
  input  wire logic [ID_W-1:0]   in_server_id,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [1:0]        out_status,
  output      logic [ID_W-1:0]   out_found_id
);

  localparam int SW    = $clog2(TABLE_ENTRIES);
  localparam int IW    = (PATH_BYTES > 1) ? $clog2(PATH_BYTES) : 1;
  localparam int LW    = $clog2(PATH_BYTES + 2);
  localparam int RW    = $clog2(TABLE_ENTRIES + 1);
  localparam int DEPTH = (TABLE_ENTRIES + 1) * (2 ** IW);
  localparam int AW    = RW + IW;
  localparam int MW    = 1 + LW + ID_W;
  localparam logic [RW-1:0] SCR_ROW = RW'(TABLE_ENTRIES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IN   = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_COPY = 4'd3;
  localparam logic [3:0] S_META = 4'd4;
  localparam logic [3:0] S_MCHK = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_found_r, res_found_nxt;
  logic              copy_pend_r, copy_pend_nxt;
  logic [IW-1:0]     copy_idx_r, copy_idx_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              cmp_last_r, cmp_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_found_id_r, out_found_id_nxt;

  logic              in_acc;
  logic              first_beat;
  logic [HASH_W-1:0] h_base;
  logic [HASH_W-1:0] h_new;
  logic [LW-1:0]     cnt_inc;

  logic              mod_start;
  logic              mod_done;
  logic [SW-1:0]     mod_rem;

  logic              path_wr_en;
  logic [AW-1:0]     path_wr_addr;
  logic [BYTE_W-1:0] path_wr_data;
  logic [AW-1:0]     path_rd_a_addr;
  logic [AW-1:0]     path_rd_b_addr;
  logic [BYTE_W-1:0] path_rd_a;
  logic [BYTE_W-1:0] path_rd_b;

  logic [MW-1:0]     meta_mem [0:TABLE_ENTRIES-1];
  logic              meta_wr_en;
  logic [SW-1:0]     meta_wr_addr;
  logic [MW-1:0]     meta_wr_data;
  logic [SW-1:0]     meta_rd_addr;
  logic [MW-1:0]     meta_q;
  logic              meta_valid;
  logic [LW-1:0]     meta_len;
  logic [ID_W-1:0]   meta_id;

  assign in_stall   = (state_r != S_IN);
  assign in_acc     = in_valid && !in_stall;
  assign first_beat = (cnt_r == '0);
  assign h_base     = first_beat ? '0 : hash_r;
  assign h_new      = {{(HASH_W - BYTE_W){in_path_byte[BYTE_W-1]}}, in_path_byte}
                      + (h_base << 5) - h_base;
  assign cnt_inc    = (cnt_r <= LW'(PATH_BYTES)) ? cnt_r + LW'(1) : cnt_r;
  assign mod_start  = in_acc && in_last_byte;

  assign meta_valid = meta_q[MW-1];
  assign meta_len   = meta_q[LW+ID_W-1:ID_W];
  assign meta_id    = meta_q[ID_W-1:0];

  // slot info arrives the cycle after the remainder, so address it from the unit directly
  assign meta_rd_addr   = (state_r == S_MOD) ? mod_rem : slot_r;
  assign path_rd_a_addr = {SCR_ROW, idx_r[IW-1:0]};
  assign path_rd_b_addr = {RW'(slot_r), idx_r[IW-1:0]};

  skdml_mod_unit #(
    .DIVISOR (TABLE_ENTRIES),
    .SW      (SW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (h_new),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  skdml_path_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_path (
    .clk       (clk),
    .wr_en     (path_wr_en),
    .wr_addr   (path_wr_addr),
    .wr_data   (path_wr_data),
    .rd_a_addr (path_rd_a_addr),
    .rd_b_addr (path_rd_b_addr),
    .rd_a_data (path_rd_a),
    .rd_b_data (path_rd_b)
  );

  always_ff @(posedge clk) begin
    if (meta_wr_en) begin
      meta_mem[meta_wr_addr] <= meta_wr_data;
    end
    meta_q <= meta_mem[meta_rd_addr];
  end

  always_comb begin
    state_nxt        = state_r;
    hash_nxt         = hash_r;
    cnt_nxt          = cnt_r;
    kind_nxt         = kind_r;
    id_nxt           = id_r;
    len_nxt          = len_r;
    slot_nxt         = slot_r;
    idx_nxt          = idx_r;
    clr_nxt          = clr_r;
    res_status_nxt   = res_status_r;
    res_found_nxt    = res_found_r;
    copy_pend_nxt    = 1'b0;
    copy_idx_nxt     = copy_idx_r;
    cmp_v_nxt        = 1'b0;
    cmp_last_nxt     = cmp_last_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_found_id_nxt = out_found_id_r;

    path_wr_en   = 1'b0;
    path_wr_addr = {SCR_ROW, cnt_r[IW-1:0]};
    path_wr_data = in_path_byte;
    meta_wr_en   = 1'b0;
    meta_wr_addr = slot_r;
    meta_wr_data = '0;

    case (state_r)
      S_CLR: begin
        meta_wr_en   = 1'b1;
        meta_wr_addr = clr_r;
        clr_nxt      = clr_r + SW'(1);
        if (clr_r == SW'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IN;
        end
      end
      S_IN: begin
        if (in_acc) begin
          kind_nxt   = first_beat ? in_action : kind_r;
          path_wr_en = (cnt_r < LW'(PATH_BYTES));
          if (in_last_byte) begin
            len_nxt   = cnt_inc;
            id_nxt    = in_server_id;
            cnt_nxt   = '0;
            hash_nxt  = '0;
            state_nxt = S_MOD;
          end else begin
            cnt_nxt  = cnt_inc;
            hash_nxt = h_new;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_nxt      = mod_rem;
          idx_nxt       = '0;
          res_found_nxt = '0;
          if (len_r > LW'(PATH_BYTES)) begin
            res_status_nxt = ST_LONG;
            state_nxt      = S_RES;
          end else begin
            case (kind_r)
              ACT_ADD: begin
                state_nxt = S_COPY;
              end
              ACT_DEL: begin
                meta_wr_en     = 1'b1;
                meta_wr_addr   = mod_rem;
                res_status_nxt = ST_DONE;
                state_nxt      = S_RES;
              end
              default: begin
                state_nxt = S_MCHK;
              end
            endcase
          end
        end
      end
      S_COPY: begin
        // read the scratch byte now, write it into the slot row next cycle
        copy_pend_nxt = 1'b1;
        copy_idx_nxt  = idx_r[IW-1:0];
        idx_nxt       = idx_r + LW'(1);
        if (idx_r == len_r - LW'(1)) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        meta_wr_en     = 1'b1;
        meta_wr_data   = {1'b1, len_r, id_r};
        res_status_nxt = ST_DONE;
        state_nxt      = S_RES;
      end
      S_MCHK: begin
        if (meta_valid && meta_len == len_r) begin
          id_nxt    = meta_id;
          state_nxt = S_CMP;
        end else begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_RES;
        end
      end
      S_CMP: begin
        if (cmp_v_r && path_rd_a != path_rd_b) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_RES;
        end else if (cmp_v_r && cmp_last_r) begin
          res_status_nxt = ST_DONE;
          res_found_nxt  = id_r;
          state_nxt      = S_RES;
        end else if (idx_r != len_r) begin
          cmp_v_nxt    = 1'b1;
          cmp_last_nxt = (idx_r == len_r - LW'(1));
          idx_nxt      = idx_r + LW'(1);
        end
      end
      S_RES: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = res_status_r;
          out_found_id_nxt = res_found_r;
          state_nxt        = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase

    if (copy_pend_r) begin
      path_wr_en   = 1'b1;
      path_wr_addr = {RW'(slot_r), copy_idx_r};
      path_wr_data = path_rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      hash_r      <= '0;
      kind_r      <= ACT_ADD;
      copy_pend_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      hash_r      <= hash_nxt;
      kind_r      <= kind_nxt;
      copy_pend_r <= copy_pend_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r           <= id_nxt;
    len_r          <= len_nxt;
    slot_r         <= slot_nxt;
    idx_r          <= idx_nxt;
    res_status_r   <= res_status_nxt;
    res_found_r    <= res_found_nxt;
    copy_idx_r     <= copy_idx_nxt;
    cmp_last_r     <= cmp_last_nxt;
    out_status_r   <= out_status_nxt;
    out_found_id_r <= out_found_id_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_found_id_r;

  `SKDML_ASSERT_NOW(a_mod_done_in_wait, mod_done, state_r == S_MOD, "remainder done outside wait")
  `SKDML_ASSERT_NOW(a_slot_write_row, path_wr_en && state_r != S_IN,
                    path_wr_addr[AW-1:IW] != SCR_ROW, "slot copy aimed at scratch row")
  `SKDML_ASSERT_NEXT(a_result_staged, state_r == S_RES && (!out_valid_r || !out_stall),
                     out_valid_r && state_r == S_IN, "result beat not staged")
  `SKDML_ASSERT_NOW(a_cmp_from_walk, cmp_v_r, state_r == S_CMP, "compare data outside walk")

endmodule

`default_nettype wire
